>>> src/brm_pkg.sv
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types, constants and fixed-point helpers of the breath-rate and
// apnea monitor.
// ----------------------------------------------------------------------------
package brm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier and divider operand widths.
    localparam int MA_W  = 35;
    localparam int MB_W  = 25;
    localparam int P_W   = 60;
    localparam int NUM_W = 48;

    // Threshold clamp, gains and rate scaling.
    localparam int THR_MIN     = 50432;
    localparam int THR_MAX     = 335616;
    localparam int THR_GAIN    = 29491;
    localparam int REARM_GAIN  = 22938;
    localparam int RATE_SCALE  = 24000;
    localparam int MIN_HISTORY = 8;
    localparam logic [9:0]       RATE_MAX  = 10'd1023;
    localparam logic [NUM_W-1:0] SUMSQ_MAX = '1;

    typedef enum logic [2:0] {
        LIE_SUPINE = 3'd0,
        LIE_PRONE  = 3'd1,
        LIE_LEFT   = 3'd2,
        LIE_RIGHT  = 3'd3,
        LIE_UNSURE = 3'd4
    } t_pos;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_THR,
        CFG_ALARM_CNT,
        CFG_REFRACTORY,
        CFG_MAX_INTERVAL,
        CFG_APNEA,
        CFG_COEF_SLOW,
        CFG_COEF_HP,
        CFG_COEF_LP
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] position_threshold;
        logic [7:0]  position_alarm_count;
        logic [9:0]  refractory_ticks;
        logic [9:0]  max_interval_ticks;
        logic [15:0] apnea_ticks;
        logic [15:0] coef_slow;
        logic [15:0] coef_highpass;
        logic [15:0] coef_lowpass;
    } t_cfg;

    // One classified word passed from the front to the back.
    typedef struct packed {
        logic signed [15:0] accel_y;
        t_pos               position;
        logic               position_alert;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BASE,
        S_MUL,
        S_BASE_UPD,
        S_HP_SET,
        S_HP_UPD,
        S_LP_SET,
        S_LP_UPD,
        S_SIG,
        S_SQ_ADD,
        S_SQ_SUB,
        S_THR,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_THR_CALC,
        S_THR_CLAMP,
        S_REARM,
        S_DET,
        S_RATE,
        S_RATE_END,
        S_FIN
    } t_bstate;

    // Q0.16 product rounded to nearest, ties upward (floor of p/2^16 + 1/2).
    function automatic logic signed [P_W-17:0] rnd16(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        s = p + P_W'(32768);
        return s[P_W-1:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sh007F_FFFF) begin
            r = 24'sh7F_FFFF;
        end else if (v < -32'sh0080_0000) begin
            r = 24'sh80_0000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

>>> src/brm_ram.sv
// ----------------------------------------------------------------------------
// brm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> src/brm_front.sv
// ----------------------------------------------------------------------------
// brm_front
// Accepts sample words, classifies lying position and keeps the position
// alert, then pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module brm_front
    import brm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item
);

    logic [7:0]         r_bad_run, n_bad_run;
    logic               r_alert, n_alert;
    logic signed [16:0] w_th, w_y, w_z;
    logic [7:0]         w_alarm;
    t_pos               w_pos;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Position from the z axis first, then the y axis, against the threshold.
    assign w_th = $signed({2'b00, i_cfg.position_threshold});
    assign w_y  = 17'(i_accel_y);
    assign w_z  = 17'(i_accel_z);

    always_comb begin
        if (w_z > w_th) begin
            w_pos = LIE_SUPINE;
        end else if (w_z < -w_th) begin
            w_pos = LIE_PRONE;
        end else if (w_y > w_th) begin
            w_pos = LIE_RIGHT;
        end else if (w_y < -w_th) begin
            w_pos = LIE_LEFT;
        end else begin
            w_pos = LIE_UNSURE;
        end
    end

    // Run of off-back words; a zero alarm count acts as one.
    assign w_alarm = (i_cfg.position_alarm_count == 8'd0) ? 8'd1 : i_cfg.position_alarm_count;

    always_comb begin
        if (w_pos == LIE_PRONE || w_pos == LIE_LEFT || w_pos == LIE_RIGHT) begin
            n_bad_run = (r_bad_run == 8'hFF) ? r_bad_run : r_bad_run + 8'd1;
            n_alert   = r_alert;
        end else begin
            n_bad_run = 8'd0;
            n_alert   = 1'b0;
        end
        if (n_bad_run >= w_alarm) begin
            n_alert = 1'b1;
        end
    end

    assign o_item = '{accel_y: i_accel_y, position: w_pos, position_alert: n_alert};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_run <= 8'd0;
            r_alert   <= 1'b0;
        end else if (o_push) begin
            r_bad_run <= n_bad_run;
            r_alert   <= n_alert;
        end
    end

endmodule

>>> src/brm_queue.sv
// ----------------------------------------------------------------------------
// brm_queue
// Two-entry queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module brm_queue
    import brm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_item  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> src/brm_back.sv
// ----------------------------------------------------------------------------
// brm_back
// Sequenced datapath: band-pass filter, RMS threshold, peak detector, rate
// average and apnea timer, sharing one multiplier, one divider and one
// square-root unit. Holds the result in an output register.
// ----------------------------------------------------------------------------
module brm_back
    import brm_pkg::*;
#(
    parameter int HISTORY_DEPTH  = 64,
    parameter int INTERVAL_DEPTH = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_position,
    output logic               o_position_alert,
    output logic               o_breath_detected,
    output logic [9:0]         o_breath_rate,
    output logic               o_apnea,
    output logic signed [23:0] o_filtered_signal
);

    localparam int HIDX_W  = $clog2(HISTORY_DEPTH);
    localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int IIDX_W  = (INTERVAL_DEPTH > 1) ? $clog2(INTERVAL_DEPTH) : 1;
    localparam int ICNT_W  = $clog2(INTERVAL_DEPTH + 1);
    localparam int ISUM_W  = 10 + ICNT_W;
    localparam int DEN_W   = (ISUM_W > HCNT_W) ? ISUM_W : HCNT_W;
    localparam int TOT_W   = 47 + HIDX_W;
    localparam int STEPS   = NUM_W / 2;
    localparam int CNT_W   = $clog2(STEPS);
    localparam int ROOT_W  = NUM_W / 2;
    localparam int SREM_W  = ROOT_W + 2;

    // Sequencer.
    t_bstate r_state, n_state, r_ret, n_ret;

    // Word in flight.
    logic signed [15:0] r_y, n_y;
    logic [2:0]         r_pos, n_pos;
    logic               r_alert, n_alert;

    // Filter state.
    logic signed [31:0] r_base, n_base, r_prev, n_prev, r_hp, n_hp, r_lp, n_lp;
    logic               r_primed, n_primed;
    logic signed [32:0] r_ac, n_ac;
    logic signed [23:0] r_sig, n_sig;

    // Shared multiplier.
    logic signed [MA_W-1:0] r_ma, n_ma;
    logic signed [MB_W-1:0] r_mb, n_mb;
    logic signed [P_W-1:0]  r_prod, n_prod, w_prod;

    // Signal history and running sum of squares.
    logic signed [23:0] r_old, n_old;
    logic [HIDX_W-1:0]  r_hidx, n_hidx;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt;
    logic               r_full, n_full;
    logic [TOT_W-1:0]   r_tot, n_tot;
    logic [23:0]        w_rd_data;

    // Shared divider and square root.
    logic [NUM_W-1:0]  r_dq, n_dq;
    logic [DEN_W-1:0]  r_drem, n_drem, r_dden, n_dden;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_sval, n_sval;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [SREM_W-1:0] r_srem, n_srem;

    // Detector.
    logic [18:0]       r_thr, n_thr;
    logic [16:0]       r_rearm, n_rearm;
    logic [9:0]        r_ivl [INTERVAL_DEPTH];
    logic [9:0]        n_ivl [INTERVAL_DEPTH];
    logic [IIDX_W-1:0] r_iidx, n_iidx;
    logic [ICNT_W-1:0] r_icnt, n_icnt;
    logic [ISUM_W-1:0] r_isum, n_isum;
    logic [15:0]       r_tsp, n_tsp;
    logic              r_seek, n_seek, r_peak, n_peak, r_found, n_found;
    logic [9:0]        r_rate, n_rate;

    // Output register.
    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_o_pos, n_o_pos;
    logic               r_o_alert, n_o_alert, r_o_det, n_o_det, r_o_apnea, n_o_apnea;
    logic [9:0]         r_o_rate, n_o_rate;
    logic signed [23:0] r_o_sig, n_o_sig;

    // Helpers.
    logic signed [23:0]      w_y8;
    logic signed [32:0]      w_ac;
    logic signed [P_W-17:0]  w_rnd;
    logic [NUM_W-1:0]        w_sumsat;
    logic [DEN_W:0]          w_rem1, w_rem2, w_rem1s, w_rem2s;
    logic                    w_ge1, w_ge2;
    logic [SREM_W+1:0]       w_st, w_trial;
    logic                    w_sge;
    logic                    w_short, w_refr_ok, w_above, w_below, w_inwin, w_hit;
    logic                    w_last;
    logic [15:0]             w_tsp0;

    assign w_prod   = P_W'(r_ma) * P_W'(r_mb);
    assign w_rnd    = rnd16(r_prod);
    assign w_y8     = {r_y, 8'h00};
    assign w_ac     = 33'(w_y8) - 33'(r_base);
    assign w_sumsat = (r_tot > TOT_W'(SUMSQ_MAX)) ? SUMSQ_MAX : r_tot[NUM_W-1:0];
    assign w_last   = (r_cnt == CNT_W'(STEPS - 1));

    // Divider: two restoring steps per cycle.
    assign w_rem1  = {r_drem, r_dq[NUM_W-1]};
    assign w_ge1   = (w_rem1 >= {1'b0, r_dden});
    assign w_rem1s = w_ge1 ? (w_rem1 - {1'b0, r_dden}) : w_rem1;
    assign w_rem2  = {w_rem1s[DEN_W-1:0], r_dq[NUM_W-2]};
    assign w_ge2   = (w_rem2 >= {1'b0, r_dden});
    assign w_rem2s = w_ge2 ? (w_rem2 - {1'b0, r_dden}) : w_rem2;

    // Square root: one result bit per cycle.
    assign w_st    = {r_srem, r_sval[NUM_W-1:NUM_W-2]};
    assign w_trial = (SREM_W + 2)'({r_root, 2'b01});
    assign w_sge   = (w_st >= w_trial);

    // Detector conditions.
    assign w_short   = (r_hcnt < HCNT_W'(MIN_HISTORY));
    assign w_refr_ok = (r_tsp >= 16'(i_cfg.refractory_ticks));
    assign w_above   = (25'(r_sig) > $signed(25'(r_thr)));
    assign w_below   = (25'(r_sig) < -$signed(25'(r_rearm)));
    assign w_inwin   = (r_tsp <= 16'(i_cfg.max_interval_ticks));
    assign w_hit     = w_refr_ok && r_seek && w_above && w_inwin;
    assign w_tsp0    = r_peak ? 16'd0 : r_tsp;

    assign o_pop = (r_state == S_IDLE) && i_item_valid && (!r_ovalid || i_out_ready);

    brm_ram #(
        .WIDTH (24),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_SQ_ADD),
        .i_wr_addr (r_hidx),
        .i_wr_data (r_sig),
        .i_rd_en   (o_pop),
        .i_rd_addr (r_hidx),
        .o_rd_data (w_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (o_pop) n_state = S_BASE;
            S_BASE:      n_state = S_MUL;
            S_MUL:       n_state = r_ret;
            S_BASE_UPD:  n_state = S_HP_SET;
            S_HP_SET:    n_state = S_MUL;
            S_HP_UPD:    n_state = S_LP_SET;
            S_LP_SET:    n_state = S_MUL;
            S_LP_UPD:    n_state = S_SIG;
            S_SIG:       n_state = S_MUL;
            S_SQ_ADD:    n_state = S_MUL;
            S_SQ_SUB:    n_state = S_THR;
            S_THR:       n_state = w_short ? S_THR_CALC : S_DIV;
            S_DIV:       if (w_last) n_state = r_ret;
            S_SQRT_INIT: n_state = S_SQRT;
            S_SQRT:      if (w_last) n_state = S_THR_CALC;
            S_THR_CALC:  n_state = S_MUL;
            S_THR_CLAMP: n_state = S_MUL;
            S_REARM:     n_state = S_DET;
            S_DET:       n_state = w_hit ? S_RATE : S_FIN;
            S_RATE:      n_state = (r_isum == '0) ? S_FIN : S_DIV;
            S_RATE_END:  n_state = S_FIN;
            S_FIN:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath updates driven by the state.
    always_comb begin
        n_ret = r_ret;     n_y = r_y;       n_pos = r_pos;   n_alert = r_alert;
        n_base = r_base;   n_prev = r_prev; n_hp = r_hp;     n_lp = r_lp;
        n_primed = r_primed; n_ac = r_ac;   n_sig = r_sig;
        n_ma = r_ma;       n_mb = r_mb;     n_prod = r_prod;
        n_old = r_old;     n_hidx = r_hidx; n_hcnt = r_hcnt; n_full = r_full;
        n_tot = r_tot;
        n_dq = r_dq;       n_drem = r_drem; n_dden = r_dden; n_cnt = r_cnt;
        n_sval = r_sval;   n_root = r_root; n_srem = r_srem;
        n_thr = r_thr;     n_rearm = r_rearm; n_ivl = r_ivl;
        n_iidx = r_iidx;   n_icnt = r_icnt; n_isum = r_isum; n_tsp = r_tsp;
        n_seek = r_seek;   n_peak = r_peak; n_found = r_found; n_rate = r_rate;
        n_ovalid = r_ovalid && !i_out_ready;
        n_o_pos = r_o_pos; n_o_alert = r_o_alert; n_o_det = r_o_det;
        n_o_apnea = r_o_apnea; n_o_rate = r_o_rate; n_o_sig = r_o_sig;

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_y     = i_item.accel_y;
                    n_pos   = i_item.position;
                    n_alert = i_item.position_alert;
                    n_peak  = 1'b0;
                    n_found = 1'b0;
                    n_full  = (r_hcnt == HCNT_W'(HISTORY_DEPTH));
                end
            end
            // The first word only primes the baseline.
            S_BASE: begin
                n_old = w_rd_data;
                if (!r_primed) begin
                    n_base   = 32'(w_y8);
                    n_primed = 1'b1;
                    n_sig    = '0;
                    n_ma     = '0;
                    n_mb     = '0;
                    n_ret    = S_SQ_ADD;
                end else begin
                    n_ma  = MA_W'(w_y8) - MA_W'(r_base);
                    n_mb  = MB_W'({1'b0, i_cfg.coef_slow});
                    n_ret = S_BASE_UPD;
                end
            end
            S_MUL: begin
                n_prod = w_prod;
            end
            S_BASE_UPD: begin
                n_base = sat32(48'(r_base) + 48'(w_rnd));
            end
            S_HP_SET: begin
                n_ac  = w_ac;
                n_ma  = MA_W'(r_hp) + MA_W'(w_ac) - MA_W'(r_prev);
                n_mb  = MB_W'({1'b0, i_cfg.coef_highpass});
                n_ret = S_HP_UPD;
            end
            S_HP_UPD: begin
                n_hp   = sat32(48'(w_rnd));
                n_prev = sat32(48'(r_ac));
            end
            S_LP_SET: begin
                n_ma  = MA_W'(r_hp) - MA_W'(r_lp);
                n_mb  = MB_W'({1'b0, i_cfg.coef_lowpass});
                n_ret = S_LP_UPD;
            end
            S_LP_UPD: begin
                n_lp = sat32(48'(r_lp) + 48'(w_rnd));
            end
            S_SIG: begin
                n_sig = sat24(r_lp);
                n_ma  = MA_W'(sat24(r_lp));
                n_mb  = MB_W'(sat24(r_lp));
                n_ret = S_SQ_ADD;
            end
            // Store the new sample and add its square; square the evicted one.
            S_SQ_ADD: begin
                n_tot  = r_tot + TOT_W'(r_prod[47:0]);
                n_hidx = (r_hidx == HIDX_W'(HISTORY_DEPTH - 1)) ? '0 : r_hidx + 1'b1;
                if (r_hcnt != HCNT_W'(HISTORY_DEPTH)) begin
                    n_hcnt = r_hcnt + 1'b1;
                end
                n_ma  = MA_W'(r_old);
                n_mb  = MB_W'(r_old);
                n_ret = S_SQ_SUB;
            end
            S_SQ_SUB: begin
                if (r_full) begin
                    n_tot = r_tot - TOT_W'(r_prod[47:0]);
                end
            end
            // Mean square by division, then its square root.
            S_THR: begin
                if (w_short) begin
                    n_root = '0;
                end else begin
                    n_dq   = w_sumsat;
                    n_dden = DEN_W'(r_hcnt);
                    n_drem = '0;
                    n_cnt  = '0;
                    n_ret  = S_SQRT_INIT;
                end
            end
            S_DIV: begin
                n_dq   = {r_dq[NUM_W-3:0], w_ge1, w_ge2};
                n_drem = w_rem2s[DEN_W-1:0];
                n_cnt  = r_cnt + 1'b1;
            end
            S_SQRT_INIT: begin
                n_sval = r_dq;
                n_root = '0;
                n_srem = '0;
                n_cnt  = '0;
            end
            S_SQRT: begin
                n_sval = {r_sval[NUM_W-3:0], 2'b00};
                n_srem = w_sge ? SREM_W'(w_st - w_trial) : SREM_W'(w_st);
                n_root = {r_root[ROOT_W-2:0], w_sge};
                n_cnt  = r_cnt + 1'b1;
            end
            S_THR_CALC: begin
                n_ma  = MA_W'(r_root);
                n_mb  = MB_W'(THR_GAIN);
                n_ret = S_THR_CLAMP;
            end
            S_THR_CLAMP: begin
                if (w_rnd < 44'(THR_MIN)) begin
                    n_thr = 19'(THR_MIN);
                end else if (w_rnd > 44'(THR_MAX)) begin
                    n_thr = 19'(THR_MAX);
                end else begin
                    n_thr = w_rnd[18:0];
                end
                n_ma  = MA_W'(n_thr);
                n_mb  = MB_W'(REARM_GAIN);
                n_ret = S_REARM;
            end
            S_REARM: begin
                n_rearm = w_rnd[16:0];
            end
            // Peak search with refractory hold and re-arm below minus the re-arm level.
            S_DET: begin
                if (w_refr_ok) begin
                    if (r_seek) begin
                        if (w_above) begin
                            n_peak = 1'b1;
                            n_seek = 1'b0;
                            if (w_inwin) begin
                                n_found       = 1'b1;
                                n_ivl[r_iidx] = r_tsp[9:0];
                                n_isum        = r_isum + ISUM_W'(r_tsp[9:0])
                                    - ((r_icnt == ICNT_W'(INTERVAL_DEPTH)) ?
                                       ISUM_W'(r_ivl[r_iidx]) : '0);
                                n_iidx = (r_iidx == IIDX_W'(INTERVAL_DEPTH - 1)) ?
                                         '0 : r_iidx + 1'b1;
                                if (r_icnt != ICNT_W'(INTERVAL_DEPTH)) begin
                                    n_icnt = r_icnt + 1'b1;
                                end
                            end
                        end
                    end else if (w_below) begin
                        n_seek = 1'b1;
                    end
                end
            end
            S_RATE: begin
                if (r_isum == '0) begin
                    n_rate = RATE_MAX;
                end else begin
                    n_dq   = NUM_W'(r_icnt) * NUM_W'(RATE_SCALE) + NUM_W'(r_isum >> 1);
                    n_dden = DEN_W'(r_isum);
                    n_drem = '0;
                    n_cnt  = '0;
                    n_ret  = S_RATE_END;
                end
            end
            S_RATE_END: begin
                n_rate = (r_dq > NUM_W'(RATE_MAX)) ? RATE_MAX : r_dq[9:0];
            end
            // Apnea timer and result word.
            S_FIN: begin
                n_tsp     = (w_tsp0 == 16'hFFFF) ? w_tsp0 : w_tsp0 + 16'd1;
                n_ovalid  = 1'b1;
                n_o_pos   = r_pos;
                n_o_alert = r_alert;
                n_o_det   = r_found;
                n_o_rate  = r_rate;
                n_o_apnea = (w_tsp0 >= i_cfg.apnea_ticks);
                n_o_sig   = r_sig;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_base   <= '0;
            r_prev   <= '0;
            r_hp     <= '0;
            r_lp     <= '0;
            r_hidx   <= '0;
            r_hcnt   <= '0;
            r_tot    <= '0;
            r_iidx   <= '0;
            r_icnt   <= '0;
            r_isum   <= '0;
            r_tsp    <= '0;
            r_seek   <= 1'b1;
            r_rate   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
            r_base   <= n_base;
            r_prev   <= n_prev;
            r_hp     <= n_hp;
            r_lp     <= n_lp;
            r_hidx   <= n_hidx;
            r_hcnt   <= n_hcnt;
            r_tot    <= n_tot;
            r_iidx   <= n_iidx;
            r_icnt   <= n_icnt;
            r_isum   <= n_isum;
            r_tsp    <= n_tsp;
            r_seek   <= n_seek;
            r_rate   <= n_rate;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;   r_y    <= n_y;    r_pos  <= n_pos;  r_alert <= n_alert;
        r_ac    <= n_ac;    r_sig  <= n_sig;
        r_ma    <= n_ma;    r_mb   <= n_mb;   r_prod <= n_prod;
        r_old   <= n_old;   r_full <= n_full;
        r_dq    <= n_dq;    r_drem <= n_drem; r_dden <= n_dden; r_cnt <= n_cnt;
        r_sval  <= n_sval;  r_root <= n_root; r_srem <= n_srem;
        r_thr   <= n_thr;   r_rearm <= n_rearm; r_ivl <= n_ivl;
        r_peak  <= n_peak;  r_found <= n_found;
        r_o_pos <= n_o_pos; r_o_alert <= n_o_alert; r_o_det <= n_o_det;
        r_o_apnea <= n_o_apnea; r_o_rate <= n_o_rate; r_o_sig <= n_o_sig;
    end

    assign o_out_valid       = r_ovalid;
    assign o_position        = r_o_pos;
    assign o_position_alert  = r_o_alert;
    assign o_breath_detected = r_o_det;
    assign o_breath_rate     = r_o_rate;
    assign o_apnea           = r_o_apnea;
    assign o_filtered_signal = r_o_sig;

endmodule

>>> src/breath_rate_apnea_monitor_unit.sv
// ----------------------------------------------------------------------------
// breath_rate_apnea_monitor_unit
// Breath-rate and apnea monitor: position classification in the front,
// filtering and peak detection in the back, a short queue between them.
//
//   Channel  Direction  Handshake                  Word
//   in       sink       i_in_valid / o_in_ready    accel_y, accel_z
//   out      source     o_out_valid / i_out_ready  position .. filtered_signal
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// The back takes no new word until it has finished the last one; the shared
// divider (two quotient bits a cycle) and the bit-serial square root set how
// long a word holds it, longer when a breath is accepted. While fewer than
// eight samples are held the division and the square root are skipped.
// The front takes a new word each cycle while the two-entry queue has room.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds its word; the back then stops taking new words.
// ----------------------------------------------------------------------------
module breath_rate_apnea_monitor_unit
    import brm_pkg::*;
#(
    parameter int HISTORY_DEPTH  = 64,
    parameter int INTERVAL_DEPTH = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [15:0]    i_accel_y,
    input  logic signed [15:0]    i_accel_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_position,
    output logic                  o_position_alert,
    output logic                  o_breath_detected,
    output logic [9:0]            o_breath_rate,
    output logic                  o_apnea,
    output logic signed [23:0]    o_filtered_signal,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item w_push_item, w_q_item;
    logic  w_push, w_pop, w_q_valid, w_q_full;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_threshold   <= 15'd9836;
            r_cfg.position_alarm_count <= 8'd25;
            r_cfg.refractory_ticks     <= 10'd38;
            r_cfg.max_interval_ticks   <= 10'd187;
            r_cfg.apnea_ticks          <= 16'd375;
            r_cfg.coef_slow            <= 16'd3874;
            r_cfg.coef_highpass        <= 16'd63929;
            r_cfg.coef_lowpass         <= 16'd9405;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POS_THR:      r_cfg.position_threshold   <= i_cfg_data[14:0];
                CFG_ALARM_CNT:    r_cfg.position_alarm_count <= i_cfg_data[7:0];
                CFG_REFRACTORY:   r_cfg.refractory_ticks     <= i_cfg_data[9:0];
                CFG_MAX_INTERVAL: r_cfg.max_interval_ticks   <= i_cfg_data[9:0];
                CFG_APNEA:        r_cfg.apnea_ticks          <= i_cfg_data;
                CFG_COEF_SLOW:    r_cfg.coef_slow            <= i_cfg_data;
                CFG_COEF_HP:      r_cfg.coef_highpass        <= i_cfg_data;
                CFG_COEF_LP:      r_cfg.coef_lowpass         <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    brm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    brm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    brm_back #(
        .HISTORY_DEPTH  (HISTORY_DEPTH),
        .INTERVAL_DEPTH (INTERVAL_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_item_valid      (w_q_valid),
        .i_item            (w_q_item),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_position        (o_position),
        .o_position_alert  (o_position_alert),
        .o_breath_detected (o_breath_detected),
        .o_breath_rate     (o_breath_rate),
        .o_apnea           (o_apnea),
        .o_filtered_signal (o_filtered_signal)
    );

endmodule

>>> src/brm_checker.sv
// ----------------------------------------------------------------------------
// brm_checker
// Port-level checks of the monitor, bound to the top level.
// ----------------------------------------------------------------------------
module brm_checker
    import brm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [2:0]            o_position,
    input logic                  o_position_alert,
    input logic                  o_breath_detected,
    input logic [9:0]            o_breath_rate,
    input logic signed [23:0]    o_filtered_signal
);

    // No result word straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_filtered_signal) && $stable(o_breath_rate))
        else $error("stalled result word changed");

    // An accepted breath always leaves a non-zero rate.
    a_rate_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_breath_detected |-> o_breath_rate != 10'd0)
        else $error("breath accepted with zero rate");

    // The alert only stands while the sleeper is off the back.
    a_alert_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_position_alert |->
            o_position != LIE_SUPINE && o_position != LIE_UNSURE)
        else $error("position alert on back or unknown position");

endmodule

bind breath_rate_apnea_monitor_unit brm_checker u_brm_checker (.*);
